// ----- sv/tsm_pkg.sv -----
// Shared widths, register codes and the divider stage record for the touch map.
// Used by every module of the touch_raw_to_screen_map block; no dependencies.
package tsm_pkg;

  localparam int unsigned RAW_W       = 12;
  localparam int unsigned SPAN_W      = 12;
  localparam int unsigned DIFF_W      = RAW_W + 1;
  localparam int unsigned PROD_W      = RAW_W + SPAN_W;
  localparam int unsigned DIV_STEPS   = SPAN_W;
  localparam int unsigned NLO_W       = PROD_W - DIV_STEPS;
  localparam int unsigned FRONT_STG   = 3;
  localparam int unsigned NSTG        = FRONT_STG + DIV_STEPS + 1;

  localparam int unsigned OUT_X_W     = 9;
  localparam int unsigned OUT_Y_W     = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_X_W - OUT_Y_W;

  localparam int unsigned CFG_AW      = 4;
  localparam int unsigned CFG_DW      = 32;

  localparam logic [1:0] REG_X_LEFT   = 2'd0;
  localparam logic [1:0] REG_X_RIGHT  = 2'd1;
  localparam logic [1:0] REG_Y_TOP    = 2'd2;
  localparam logic [1:0] REG_Y_BOTTOM = 2'd3;

  // One restoring-division step's working set plus the sideband flags.
  typedef struct packed {
    logic [SPAN_W-1:0] rem;
    logic [NLO_W-1:0]  num_lo;
    logic [SPAN_W-1:0] quo;
    logic [SPAN_W-1:0] den;
    logic              neg;
    logic              sat;
  } div_t;

endpackage

// ----- sv/touch_raw_to_screen_map_top.sv -----
// Touch raw-to-screen map: 16-stage pipeline that accepts one sample pair every cycle
// when the output is taken. The 12-step pipelined divider yields one quotient bit per stage.
// Bubbles collapse, so input transfers continue while a result waits at the output,
// as long as any stage is empty.
// rst_ni clears the calibration registers and all stage valid bits.
// Depends on tsm_pkg and tsm_axis.
module touch_raw_to_screen_map_top #(
  parameter int unsigned SCREEN_W = 320,
  parameter int unsigned SCREEN_H = 240
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [11:0] raw_x, [23:12] raw_y
  input  logic [tsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [8:0] screen_x, [16:9] screen_y, [23:17] zero
  output logic [tsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsm_pkg::CFG_AW-1:0]         paddr,
  input  logic [tsm_pkg::CFG_DW-1:0]         pwdata,
  output logic [tsm_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);

  logic [tsm_pkg::RAW_W-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic                       cfg_we;
  logic                       degen;
  logic [tsm_pkg::NSTG-1:0]   valid_q, rdy, vin, en;
  logic [tsm_pkg::SPAN_W-1:0] res_x, res_y;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q <= '0;
      x_hi_q <= '0;
      y_lo_q <= '0;
      y_hi_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        tsm_pkg::REG_X_LEFT:   x_lo_q <= pwdata[tsm_pkg::RAW_W-1:0];
        tsm_pkg::REG_X_RIGHT:  x_hi_q <= pwdata[tsm_pkg::RAW_W-1:0];
        tsm_pkg::REG_Y_TOP:    y_lo_q <= pwdata[tsm_pkg::RAW_W-1:0];
        tsm_pkg::REG_Y_BOTTOM: y_hi_q <= pwdata[tsm_pkg::RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tsm_pkg::REG_X_LEFT:   prdata = tsm_pkg::CFG_DW'(x_lo_q);
      tsm_pkg::REG_X_RIGHT:  prdata = tsm_pkg::CFG_DW'(x_hi_q);
      tsm_pkg::REG_Y_TOP:    prdata = tsm_pkg::CFG_DW'(y_lo_q);
      tsm_pkg::REG_Y_BOTTOM: prdata = tsm_pkg::CFG_DW'(y_hi_q);
      default:               prdata = '0;
    endcase
  end

  assign degen = (x_lo_q == x_hi_q) || (y_lo_q == y_hi_q);

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    rdy[tsm_pkg::NSTG-1] = !valid_q[tsm_pkg::NSTG-1] || m_axis_tready_i;
    for (int k = tsm_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin = {valid_q[tsm_pkg::NSTG-2:0], s_axis_tvalid_i};
    en  = rdy & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < tsm_pkg::NSTG; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  tsm_axis #(.SPAN(SCREEN_W)) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (s_axis_tdata_i[tsm_pkg::RAW_W-1:0]),
    .lo_i    (x_lo_q),
    .hi_i    (x_hi_q),
    .degen_i (degen),
    .res_o   (res_x)
  );

  tsm_axis #(.SPAN(SCREEN_H)) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (s_axis_tdata_i[2*tsm_pkg::RAW_W-1:tsm_pkg::RAW_W]),
    .lo_i    (y_lo_q),
    .hi_i    (y_hi_q),
    .degen_i (degen),
    .res_o   (res_y)
  );

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[tsm_pkg::NSTG-1];
  assign m_axis_tdata_o  = {tsm_pkg::OUT_PAD_W'(0),
                            res_y[tsm_pkg::OUT_Y_W-1:0],
                            res_x[tsm_pkg::OUT_X_W-1:0]};

`ifndef SYNTHESIS
  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_x <= tsm_pkg::SPAN_W'(SCREEN_W)))
    else $error("screen_x beyond span");

  a_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_y <= tsm_pkg::SPAN_W'(SCREEN_H)))
    else $error("screen_y beyond span");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&valid_q) && !m_axis_tready_i))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

// ----- sv/tsm_div_step.sv -----
// One registered restoring-division step: one quotient bit per stage.
// Depends on tsm_pkg for the div_t stage record.
module tsm_div_step (
  input  logic          clk_i,
  input  logic          en_i,
  input  tsm_pkg::div_t d_i,
  output tsm_pkg::div_t d_o
);

  logic [tsm_pkg::SPAN_W:0]   trial;
  logic [tsm_pkg::SPAN_W:0]   sub;
  logic                       ge;
  tsm_pkg::div_t              d_d;
  tsm_pkg::div_t              d_q;

  always_comb begin
    trial    = {d_i.rem, d_i.num_lo[tsm_pkg::NLO_W-1]};
    sub      = trial - {1'b0, d_i.den};
    ge       = trial >= {1'b0, d_i.den};
    d_d      = d_i;
    d_d.rem  = ge ? sub[tsm_pkg::SPAN_W-1:0] : trial[tsm_pkg::SPAN_W-1:0];
    d_d.num_lo = {d_i.num_lo[tsm_pkg::NLO_W-2:0], 1'b0};
    d_d.quo  = {d_i.quo[tsm_pkg::SPAN_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// ----- sv/tsm_axis.sv -----
// Datapath for one axis: offset, scale by span, divide by calibration delta, clamp.
// Depends on tsm_pkg and tsm_div_step; stage enables come from the top level.
module tsm_axis #(
  parameter int unsigned SPAN = 320
) (
  input  logic                             clk_i,
  input  logic [tsm_pkg::NSTG-1:0]         en_i,
  input  logic [tsm_pkg::RAW_W-1:0]        raw_i,
  input  logic [tsm_pkg::RAW_W-1:0]        lo_i,
  input  logic [tsm_pkg::RAW_W-1:0]        hi_i,
  input  logic                             degen_i,
  output logic [tsm_pkg::SPAN_W-1:0]       res_o
);

  localparam logic [tsm_pkg::SPAN_W-1:0] SpanC = tsm_pkg::SPAN_W'(SPAN);

  logic signed [tsm_pkg::DIFF_W-1:0] den;
  logic [tsm_pkg::SPAN_W-1:0]        den_mag;
  logic signed [tsm_pkg::DIFF_W-1:0] diff_d, diff_q;
  logic                              neg0_q, neg1_q;
  logic [tsm_pkg::SPAN_W-1:0]        mag;
  logic [tsm_pkg::PROD_W-1:0]        prod_d, prod_q;
  tsm_pkg::div_t                     div_d;
  tsm_pkg::div_t                     chain [tsm_pkg::DIV_STEPS+1];
  tsm_pkg::div_t                     fin;
  logic [tsm_pkg::SPAN_W-1:0]        res_d, res_q;

  // The user must keep the calibration registers static while items are in flight; not enforced here.
  always_comb begin
    den     = $signed({1'b0, hi_i}) - $signed({1'b0, lo_i});
    den_mag = den[tsm_pkg::DIFF_W-1] ? tsm_pkg::SPAN_W'(-den) : den[tsm_pkg::SPAN_W-1:0];
    diff_d  = $signed({1'b0, raw_i}) - $signed({1'b0, lo_i});
    mag     = diff_q[tsm_pkg::DIFF_W-1] ? tsm_pkg::SPAN_W'(-diff_q)
                                        : diff_q[tsm_pkg::SPAN_W-1:0];
    prod_d  = tsm_pkg::PROD_W'(mag) * tsm_pkg::PROD_W'(SpanC);
  end

  // Quotient of 4096 or more always clamps, so only 12 quotient bits are needed.
  always_comb begin
    div_d        = '0;
    div_d.rem    = prod_q[tsm_pkg::PROD_W-1 -: tsm_pkg::SPAN_W];
    div_d.num_lo = prod_q[tsm_pkg::NLO_W-1:0];
    div_d.den    = den_mag;
    div_d.neg    = neg1_q;
    div_d.sat    = prod_q >= {den_mag, tsm_pkg::NLO_W'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= diff_d;
      neg0_q <= diff_d[tsm_pkg::DIFF_W-1] ^ den[tsm_pkg::DIFF_W-1];
    end
    if (en_i[1]) begin
      prod_q <= prod_d;
      neg1_q <= neg0_q;
    end
    if (en_i[2]) begin
      chain[0] <= div_d;
    end
  end

  for (genvar k = 0; k < tsm_pkg::DIV_STEPS; k++) begin : g_div
    tsm_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en_i[tsm_pkg::FRONT_STG + k]),
      .d_i   (chain[k]),
      .d_o   (chain[k+1])
    );
  end

  // Drop negative quotients and degenerate calibrations to zero and hold large ones at the span.
  always_comb begin
    fin = chain[tsm_pkg::DIV_STEPS];
    if (degen_i || fin.neg) begin
      res_d = '0;
    end else if (fin.sat || (fin.quo > SpanC)) begin
      res_d = SpanC;
    end else begin
      res_d = fin.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[tsm_pkg::NSTG-1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- tb/touch_raw_to_screen_map_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for touch_raw_to_screen_map_top: directed probes, then random
// calibrations and sample pairs, each result checked against a known point or an in-bench mapper.
// Depends on tsm_pkg and the touch map RTL.
module touch_raw_to_screen_map_top_tb;

  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 240;
  localparam int PIPE_DEPTH  = 16;
  localparam int RAND_BLOCKS = 8;
  localparam int BLOCK_PAIRS = 162;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PROBES  = 22;
  localparam int NUM_DIR_CAL = 7;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    logic [tsm_pkg::OUT_X_W-1:0] sx;
    logic [tsm_pkg::OUT_Y_W-1:0] sy;
  } screen_pt_t;

  typedef struct packed {
    logic [tsm_pkg::RAW_W-1:0] xl;
    logic [tsm_pkg::RAW_W-1:0] xr;
    logic [tsm_pkg::RAW_W-1:0] yt;
    logic [tsm_pkg::RAW_W-1:0] yb;
  } cal_set_t;

  // cal selects a row of dir_cal; known rows carry the expected point in pt
  typedef struct packed {
    logic [2:0]                cal;
    logic [tsm_pkg::RAW_W-1:0] rx;
    logic [tsm_pkg::RAW_W-1:0] ry;
    logic                      known;
    screen_pt_t                pt;
  } probe_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  // [11:0] raw_x, [23:12] raw_y
  logic [tsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  // [8:0] screen_x, [16:9] screen_y, [23:17] zero
  logic [tsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                            psel            = 1'b0;
  logic                            penable         = 1'b0;
  logic                            pwrite          = 1'b0;
  logic [tsm_pkg::CFG_AW-1:0]      paddr           = '0;
  logic [tsm_pkg::CFG_DW-1:0]      pwdata          = '0;
  logic [tsm_pkg::CFG_DW-1:0]      prdata;
  logic                            pready;

  logic [tsm_pkg::RAW_W-1:0] cal_reg [4] = '{default: '0};
  screen_pt_t       expected_pts [$];
  int               errors          = 0;
  int               results_seen    = 0;
  int               pairs_sent      = 0;
  int               cal_loads       = 0;
  int               input_stalls    = 0;
  int               hold_left       = 0;
  int               cycle_cnt       = 0;
  int               send_idle_pct   = 0;
  int               recv_stall_pct  = 0;

  cal_set_t dir_cal [NUM_DIR_CAL] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0},     // reset values, never written
    '{12'd0,    12'd4095, 12'd0,    12'd4095},  // full range
    '{12'd4095, 12'd0,    12'd4095, 12'd0},     // inverted full range
    '{12'd1000, 12'd3000, 12'd500,  12'd3500},  // partial: clamps on both sides
    '{12'd100,  12'd100,  12'd0,    12'd4095},  // x axis degenerate
    '{12'd0,    12'd4095, 12'd2000, 12'd2000},  // y axis degenerate
    '{12'd2048, 12'd2049, 12'd4094, 12'd4095}   // one-count spans, steepest slope
  };

  probe_t probes [NUM_PROBES] = '{
    '{3'd0, 12'd0,    12'd0,    1'b1, '{9'd0,   8'd0}},
    '{3'd0, 12'd4095, 12'd4095, 1'b1, '{9'd0,   8'd0}},
    '{3'd1, 12'd0,    12'd0,    1'b1, '{9'd0,   8'd0}},
    '{3'd1, 12'd4095, 12'd4095, 1'b1, '{9'd320, 8'd240}},
    '{3'd1, 12'd2048, 12'd1024, 1'b0, '{9'd0,   8'd0}},
    '{3'd1, 12'd1,    12'd4094, 1'b0, '{9'd0,   8'd0}},
    '{3'd2, 12'd0,    12'd0,    1'b1, '{9'd320, 8'd240}},
    '{3'd2, 12'd4095, 12'd4095, 1'b1, '{9'd0,   8'd0}},
    '{3'd2, 12'd2047, 12'd2048, 1'b0, '{9'd0,   8'd0}},
    '{3'd2, 12'd4094, 12'd1,    1'b0, '{9'd0,   8'd0}},
    '{3'd3, 12'd0,    12'd0,    1'b1, '{9'd0,   8'd0}},
    '{3'd3, 12'd4095, 12'd4095, 1'b1, '{9'd320, 8'd240}},
    '{3'd3, 12'd1000, 12'd500,  1'b1, '{9'd0,   8'd0}},
    '{3'd3, 12'd3000, 12'd3500, 1'b1, '{9'd320, 8'd240}},
    '{3'd3, 12'd2000, 12'd2000, 1'b0, '{9'd0,   8'd0}},
    '{3'd3, 12'd1001, 12'd3499, 1'b0, '{9'd0,   8'd0}},
    '{3'd4, 12'd4095, 12'd4095, 1'b1, '{9'd0,   8'd0}},
    '{3'd4, 12'd1234, 12'd2345, 1'b1, '{9'd0,   8'd0}},
    '{3'd5, 12'd0,    12'd4095, 1'b1, '{9'd0,   8'd0}},
    '{3'd5, 12'd4095, 12'd0,    1'b1, '{9'd0,   8'd0}},
    '{3'd6, 12'd2048, 12'd4094, 1'b1, '{9'd0,   8'd0}},
    '{3'd6, 12'd4095, 12'd0,    1'b1, '{9'd320, 8'd0}}
  };

  touch_raw_to_screen_map_top #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Signed scale of one axis, truncating toward zero, clamped to 0..span
  function automatic int map_axis(input int raw, input int lo, input int hi, input int span);
    int q;
    q = ((raw - lo) * span) / (hi - lo);
    if (q < 0) q = 0;
    if (q > span) q = span;
    return q;
  endfunction

  function automatic screen_pt_t map_touch(input logic [tsm_pkg::RAW_W-1:0] rx,
                                           input logic [tsm_pkg::RAW_W-1:0] ry);
    screen_pt_t pt;
    pt = '0;
    if (cal_reg[tsm_pkg::REG_X_RIGHT] != cal_reg[tsm_pkg::REG_X_LEFT] &&
        cal_reg[tsm_pkg::REG_Y_BOTTOM] != cal_reg[tsm_pkg::REG_Y_TOP]) begin
      pt.sx = tsm_pkg::OUT_X_W'(map_axis(rx, cal_reg[tsm_pkg::REG_X_LEFT],
                                         cal_reg[tsm_pkg::REG_X_RIGHT], SCREEN_W));
      pt.sy = tsm_pkg::OUT_Y_W'(map_axis(ry, cal_reg[tsm_pkg::REG_Y_TOP],
                                         cal_reg[tsm_pkg::REG_Y_BOTTOM], SCREEN_H));
    end
    return pt;
  endfunction

  function automatic logic [tsm_pkg::RAW_W-1:0] any_raw();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return tsm_pkg::RAW_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [tsm_pkg::RAW_W-1:0] near(input logic [tsm_pkg::RAW_W-1:0] base,
                                                     input int reach);
    int v;
    v = int'(base) + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return tsm_pkg::RAW_W'(v);
  endfunction

  function automatic cal_set_t random_cal();
    cal_set_t c;
    c = {any_raw(), any_raw(), any_raw(), any_raw()};
    case ($urandom_range(9))
      0:       c.xr = c.xl;
      1:       c.yb = c.yt;
      2, 3: begin
        c.xr = near(c.xl, 16);
        c.yb = near(c.yt, 16);
      end
      default: ;
    endcase
    return c;
  endfunction

  // Mostly uniform, with weight on the calibration corners and the field extremes
  function automatic logic [tsm_pkg::RAW_W-1:0] random_raw(
      input logic [tsm_pkg::RAW_W-1:0] lo,
      input logic [tsm_pkg::RAW_W-1:0] hi);
    case ($urandom_range(9))
      0:       return near(lo, 24);
      1:       return near(hi, 24);
      2:       return any_raw();
      default: return tsm_pkg::RAW_W'($urandom);
    endcase
  endfunction

  // Write one register, then read it back; upper write bits carry junk that must drop
  task automatic write_reg(input logic [1:0] idx, input logic [tsm_pkg::RAW_W-1:0] val);
    logic [tsm_pkg::CFG_DW-1:0] word;
    word = {(tsm_pkg::CFG_DW - tsm_pkg::RAW_W)'($urandom), val};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cal_reg[idx] = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== tsm_pkg::CFG_DW'(val))
      report_mismatch($sformatf("register %0d read %h, wrote %h", idx, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_calibration(input cal_set_t c);
    write_reg(tsm_pkg::REG_X_LEFT, c.xl);
    write_reg(tsm_pkg::REG_X_RIGHT, c.xr);
    write_reg(tsm_pkg::REG_Y_TOP, c.yt);
    write_reg(tsm_pkg::REG_Y_BOTTOM, c.yb);
    cal_loads++;
  endtask

  task automatic wait_drained();
    while (expected_pts.size() != 0) @(posedge clk_i);
  endtask

  // Called at a rising edge; returns at the edge of the transfer
  task automatic offer_pair(input logic [tsm_pkg::RAW_W-1:0] rx,
                            input logic [tsm_pkg::RAW_W-1:0] ry,
                            input screen_pt_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ry, rx};
    do begin
      @(posedge clk_i);
      if (!s_axis_tready_o) input_stalls++;
    end while (!s_axis_tready_o);
    expected_pts.push_back(want);
    pairs_sent++;
  endtask

  always @(posedge clk_i) begin : result_check
    screen_pt_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_pts.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_axis_tdata_o));
      end else begin
        want = expected_pts.pop_front();
        if (m_axis_tdata_o[tsm_pkg::OUT_X_W-1:0] !== want.sx)
          report_mismatch($sformatf("screen_x %0d, expected %0d",
                                    m_axis_tdata_o[tsm_pkg::OUT_X_W-1:0], want.sx));
        if (m_axis_tdata_o[tsm_pkg::OUT_X_W +: tsm_pkg::OUT_Y_W] !== want.sy)
          report_mismatch($sformatf("screen_y %0d, expected %0d",
                                    m_axis_tdata_o[tsm_pkg::OUT_X_W +: tsm_pkg::OUT_Y_W],
                                    want.sy));
        if (m_axis_tdata_o[tsm_pkg::OUT_TDATA_W-1 -: tsm_pkg::OUT_PAD_W] !== '0)
          report_mismatch($sformatf("pad bits %h not zero",
                          m_axis_tdata_o[tsm_pkg::OUT_TDATA_W-1 -: tsm_pkg::OUT_PAD_W]));
      end
      results_seen++;
      // one long hold-off so the pipeline fills and backs up into the input
      if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_pts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int                        cur_cal;
    cal_set_t                  cal;
    logic [tsm_pkg::RAW_W-1:0] rx;
    logic [tsm_pkg::RAW_W-1:0] ry;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_cal = 0;
    foreach (probes[i]) begin
      if (probes[i].cal != cur_cal) begin
        s_axis_tvalid_i <= 1'b0;
        wait_drained();
        cur_cal = probes[i].cal;
        load_calibration(dir_cal[cur_cal]);
      end
      offer_pair(probes[i].rx, probes[i].ry,
                 probes[i].known ? probes[i].pt : map_touch(probes[i].rx, probes[i].ry));
    end

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
      case (b % 4)
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      cal = (b == 0) ? cal_set_t'({12'd0, 12'd4095, 12'd4095, 12'd0}) : random_cal();
      load_calibration(cal);
      for (int n = 0; n < BLOCK_PAIRS; n++) begin
        rx = random_raw(cal.xl, cal.xr);
        ry = random_raw(cal.yt, cal.yb);
        offer_pair(rx, ry, map_touch(rx, ry));
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);

    $display("covered %0d sample pairs over %0d calibration loads, %0d results compared",
             pairs_sent, cal_loads, results_seen);
    $display("input held off for %0d cycles while the output was stalled", input_stalls);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
